// ===== src/rps_pkg.sv =====
package rps_pkg;

    // Signature table geometry
    localparam int SIG_COUNT  = 12;
    localparam int SIG_MAXLEN = 12;
    localparam int ALIVE_W    = 13;
    localparam int POS_W      = 4;
    localparam int SEEN_W     = POS_W + 1;

    // Bit positions in the alive vector
    localparam int BIT_HTTP_LO = 0;
    localparam int BIT_HTTP_HI = 7;
    localparam int BIT_SSH     = 8;
    localparam int BIT_PROXY1  = 9;
    localparam int BIT_PROXY2  = 10;
    localparam int BIT_TLS     = 11;
    localparam int BIT_SOCKS   = 12;

    localparam logic [POS_W-1:0]   POS_MAX   = '1;
    localparam logic [ALIVE_W-1:0] ALIVE_ALL = '1;

    // SOCKS version bytes
    localparam logic [7:0] SOCKS_V4 = 8'h04;
    localparam logic [7:0] SOCKS_V5 = 8'h05;

    // Result class codes
    localparam logic [2:0] CLASS_UNKNOWN = 3'd0;
    localparam logic [2:0] CLASS_TLS     = 3'd1;
    localparam logic [2:0] CLASS_HTTP    = 3'd2;
    localparam logic [2:0] CLASS_SSH     = 3'd3;
    localparam logic [2:0] CLASS_PROXY   = 3'd4;
    localparam logic [2:0] CLASS_SOCKS   = 3'd5;

    typedef logic [7:0] sig_row_t [SIG_MAXLEN];

    // Signature bytes, left aligned, zero padded
    localparam sig_row_t SIG_BYTES [SIG_COUNT] = '{
        '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h55, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h45, 8'h41, 8'h44, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h53, 8'h48, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h52, 8'h4F, 8'h58, 8'h59, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h00, 8'h0D, 8'h0A, 8'h51, 8'h55, 8'h49, 8'h54, 8'h0A},
        '{8'h16, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // Bytes compared per signature
    localparam logic [POS_W-1:0] SIG_LEN [SIG_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd5, 4'd8, 4'd8, 4'd7, 4'd6, 4'd4, 4'd6, 4'd12, 4'd2
    };

    // Minimum capture length per signature (TLS wants one byte beyond the compare)
    localparam logic [SEEN_W-1:0] SIG_NEED [SIG_COUNT] = '{
        5'd4, 5'd5, 5'd4, 5'd5, 5'd8, 5'd8, 5'd7, 5'd6, 5'd4, 5'd6, 5'd12, 5'd3
    };

    // One captured byte as it moves from the input register to the tracker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } rps_beat_t;

endpackage

// ===== src/raw_protocol_sniffer_unit.sv =====
// Channel   Ports                              Direction  Carries
// s_        s_valid s_ready s_data_byte s_last  in        one captured byte per request
// m_        m_valid m_ready m_proto_class       out       one class per capture
//
// One byte accepted per cycle while no stalled result blocks the input; m_valid rises
// after the last byte of a capture is accepted (input register, then result register).
// The signature tracker updates once per byte leaving the input register.
// Reset (aresetn low, synchronous) empties both registers and restarts the capture.
// A stalled result holds only a byte marked last; bytes before it keep flowing.
module raw_protocol_sniffer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_proto_class
);

    logic               in_valid_reg, in_valid_next;
    rps_pkg::rps_beat_t in_beat_reg, in_beat_next;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_class_reg, out_class_next;
    logic               advance;
    logic [2:0]         beat_class;

    // A byte leaves the input register unless it closes a capture and the result is blocked
    assign advance = in_valid_reg && (!in_beat_reg.last || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    rps_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat        (in_beat_reg),
        .advance     (advance),
        .proto_class (beat_class)
    );

    // Input register
    always_comb begin
        in_valid_next = in_valid_reg;
        in_beat_next  = in_beat_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_beat_next  = '{data_byte: s_data_byte, last: s_last};
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_class_next = out_class_reg;
        if (advance && in_beat_reg.last) begin
            out_valid_next = 1'b1;
            out_class_next = beat_class;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_beat_reg   <= in_beat_next;
        out_class_reg <= out_class_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_proto_class = out_class_reg;

endmodule

// ===== src/rps_tracker.sv =====
module rps_tracker (
    input  logic              aclk,
    input  logic              aresetn,
    input  rps_pkg::rps_beat_t beat,
    input  logic              advance,
    output logic [2:0]        proto_class
);

    logic [rps_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [rps_pkg::ALIVE_W-1:0] alive_reg, alive_next;
    logic [rps_pkg::ALIVE_W-1:0] alive_upd;
    logic [rps_pkg::SEEN_W-1:0]  seen;
    logic [rps_pkg::SIG_COUNT-1:0] sig_hit;

    // Knock out every signature the current byte disagrees with
    always_comb begin
        alive_upd = alive_reg;
        for (int i = 0; i < rps_pkg::SIG_COUNT; i++) begin
            if (pos_reg < rps_pkg::SIG_LEN[i] &&
                beat.data_byte != rps_pkg::SIG_BYTES[i][pos_reg]) begin
                alive_upd[i] = 1'b0;
            end
        end
        if (pos_reg == '0 && beat.data_byte != rps_pkg::SOCKS_V4 &&
            beat.data_byte != rps_pkg::SOCKS_V5) begin
            alive_upd[rps_pkg::BIT_SOCKS] = 1'b0;
        end
    end

    // Capture length including this byte
    assign seen = {1'b0, pos_reg} + rps_pkg::SEEN_W'(1);

    always_comb begin
        for (int i = 0; i < rps_pkg::SIG_COUNT; i++) begin
            sig_hit[i] = alive_upd[i] && (seen >= rps_pkg::SIG_NEED[i]);
        end
    end

    // Class by priority: tls, http, ssh, proxy, socks
    always_comb begin
        priority if (sig_hit[rps_pkg::BIT_TLS]) begin
            proto_class = rps_pkg::CLASS_TLS;
        end else if (|sig_hit[rps_pkg::BIT_HTTP_HI:rps_pkg::BIT_HTTP_LO]) begin
            proto_class = rps_pkg::CLASS_HTTP;
        end else if (sig_hit[rps_pkg::BIT_SSH]) begin
            proto_class = rps_pkg::CLASS_SSH;
        end else if (sig_hit[rps_pkg::BIT_PROXY1] || sig_hit[rps_pkg::BIT_PROXY2]) begin
            proto_class = rps_pkg::CLASS_PROXY;
        end else if (alive_upd[rps_pkg::BIT_SOCKS]) begin
            proto_class = rps_pkg::CLASS_SOCKS;
        end else begin
            proto_class = rps_pkg::CLASS_UNKNOWN;
        end
    end

    // State update: restart after the last byte, else step the position
    always_comb begin
        pos_next   = pos_reg;
        alive_next = alive_reg;
        if (advance) begin
            if (beat.last) begin
                pos_next   = '0;
                alive_next = rps_pkg::ALIVE_ALL;
            end else begin
                pos_next   = (pos_reg == rps_pkg::POS_MAX) ? pos_reg
                                                           : pos_reg + rps_pkg::POS_W'(1);
                alive_next = alive_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            alive_reg <= rps_pkg::ALIVE_ALL;
        end else begin
            pos_reg   <= pos_next;
            alive_reg <= alive_next;
        end
    end

endmodule

// ===== src/rps_checker.sv =====
module rps_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_data_byte,
    input logic       s_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_proto_class
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_proto_class))
        else $error("result changed while stalled");

    // Only defined class codes leave the block
    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_proto_class != 3'd6 && m_proto_class != 3'd7)
        else $error("undefined class code");

    // Reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Reset empties the input register, so the input side is open
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind raw_protocol_sniffer_unit rps_checker u_rps_checker (.*);

// ===== dv/sniffer_class_checker.sv =====
module sniffer_class_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [2:0] m_proto_class,
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Row indexes of the HTTP methods in the match vector
    localparam int M_GET     = 0;
    localparam int M_POST    = 1;
    localparam int M_PUT     = 2;
    localparam int M_HEAD    = 3;
    localparam int M_OPTIONS = 4;
    localparam int M_CONNECT = 5;
    localparam int M_DELETE  = 6;
    localparam int M_PATCH   = 7;

    // Capture-in-progress state of the predictor
    logic [3:0]  seen_count;
    logic [12:0] still_matching;
    logic [2:0]  class_queue [$];
    logic [2:0]  want_class;
    int          fail_tally = 0;

    // Signature text, left aligned in 12 bytes
    function automatic logic [95:0] sig_text(input int idx);
        case (idx)
            M_GET:               sig_text = {"GET ", 64'h0};
            M_POST:              sig_text = {"POST ", 56'h0};
            M_PUT:               sig_text = {"PUT ", 64'h0};
            M_HEAD:              sig_text = {"HEAD ", 56'h0};
            M_OPTIONS:           sig_text = {"OPTIONS ", 32'h0};
            M_CONNECT:           sig_text = {"CONNECT ", 32'h0};
            M_DELETE:            sig_text = {"DELETE ", 40'h0};
            M_PATCH:             sig_text = {"PATCH ", 48'h0};
            rps_pkg::BIT_SSH:    sig_text = {"SSH-", 64'h0};
            rps_pkg::BIT_PROXY1: sig_text = {"PROXY ", 48'h0};
            rps_pkg::BIT_PROXY2: sig_text = 96'h0d0a0d0a000d0a515549540a;
            rps_pkg::BIT_TLS:    sig_text = {16'h1603, 80'h0};
            default:             sig_text = '0;
        endcase
    endfunction

    // Number of bytes compared
    function automatic int sig_len(input int idx);
        case (idx)
            M_GET, M_PUT, rps_pkg::BIT_SSH:  sig_len = 4;
            M_POST, M_HEAD:                  sig_len = 5;
            M_OPTIONS, M_CONNECT:            sig_len = 8;
            M_DELETE:                        sig_len = 7;
            M_PATCH, rps_pkg::BIT_PROXY1:    sig_len = 6;
            rps_pkg::BIT_PROXY2:             sig_len = 12;
            rps_pkg::BIT_TLS:                sig_len = 2;
            default:                         sig_len = 1;
        endcase
    endfunction

    // Capture length a signature needs; TLS wants a byte past the compare
    function automatic int sig_need(input int idx);
        sig_need = (idx == rps_pkg::BIT_TLS) ? 3 : sig_len(idx);
    endfunction

    function automatic bit sig_hit(input int idx, input int seen);
        sig_hit = still_matching[idx] && (seen >= sig_need(idx));
    endfunction

    // Fold one accepted byte into the capture; queue a class on the last one
    task automatic take_byte(input logic [7:0] b, input logic fin);
        logic [95:0] txt;
        logic [2:0]  cls;
        int          n;
        int          p;
        int          seen;
        bit          http_hit;
        p = int'(seen_count);
        for (n = 0; n < rps_pkg::SIG_COUNT; n++) begin
            txt = sig_text(n);
            if (p < sig_len(n) && b != txt[95 - 8*p -: 8])
                still_matching[n] = 1'b0;
        end
        if (p == 0 && b != rps_pkg::SOCKS_V4 && b != rps_pkg::SOCKS_V5)
            still_matching[rps_pkg::BIT_SOCKS] = 1'b0;
        seen = p + 1;
        if (seen_count != 4'hF)
            seen_count = seen_count + 4'd1;
        if (fin) begin
            http_hit = 1'b0;
            for (n = M_GET; n <= M_PATCH; n++)
                if (sig_hit(n, seen))
                    http_hit = 1'b1;
            if (sig_hit(rps_pkg::BIT_TLS, seen))
                cls = rps_pkg::CLASS_TLS;
            else if (http_hit)
                cls = rps_pkg::CLASS_HTTP;
            else if (sig_hit(rps_pkg::BIT_SSH, seen))
                cls = rps_pkg::CLASS_SSH;
            else if (sig_hit(rps_pkg::BIT_PROXY1, seen) || sig_hit(rps_pkg::BIT_PROXY2, seen))
                cls = rps_pkg::CLASS_PROXY;
            else if (sig_hit(rps_pkg::BIT_SOCKS, seen))
                cls = rps_pkg::CLASS_SOCKS;
            else
                cls = rps_pkg::CLASS_UNKNOWN;
            class_queue    = {class_queue, cls};
            seen_count     = '0;
            still_matching = '1;
        end
    endtask

    // Watch both channels; compare results against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            seen_count     = '0;
            still_matching = '1;
            class_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (class_queue.size() == 0) begin
                    $error("proto_class: expected none, actual %0d", m_proto_class);
                    fail_tally++;
                end else begin
                    want_class = class_queue.pop_front();
                    if (m_proto_class !== want_class) begin
                        $error("proto_class: expected %0d, actual %0d",
                               want_class, m_proto_class);
                        fail_tally++;
                    end
                end
            end
            if (s_valid && s_ready)
                take_byte(s_data_byte, s_last);
        end
        mismatches  <= fail_tally;
        outstanding <= class_queue.size();
    end

endmodule

// ===== dv/raw_protocol_sniffer_unit_tb.sv =====
module raw_protocol_sniffer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 400;

    // Capture kinds beyond the signature table rows
    localparam int KIND_SOCKS4 = 12;
    localparam int KIND_SOCKS5 = 13;
    localparam int KIND_NOISE  = 14;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte   = 8'h00;
    logic       s_last        = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [2:0] m_proto_class;

    int         mismatches;
    int         outstanding;
    int         cycle_count   = 0;
    int         sent_items    = 0;
    int         results_taken = 0;
    bit         tx_busy       = 1'b0;
    bit         rx_busy       = 1'b0;
    bit         long_hold_done = 1'b0;
    logic [7:0] cap_bytes [$];

    always #1 aclk = ~aclk;

    raw_protocol_sniffer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_proto_class (m_proto_class)
    );

    sniffer_class_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_proto_class (m_proto_class),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one byte request; valid only drops during a gap before the byte
    task automatic offer_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (sent_items % 40 == 0)
            tx_busy = ($urandom_range(0, 2) != 0);
        gap = tx_busy ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last      <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic send_capture();
        int i;
        for (i = 0; i < cap_bytes.size(); i++)
            offer_byte(cap_bytes[i], i == cap_bytes.size() - 1);
    endtask

    // Append one byte to the capture under construction
    task automatic add_byte(input logic [7:0] b);
        cap_bytes = {cap_bytes, b};
    endtask

    task automatic load_sig(input int row);
        int i;
        for (i = 0; i < rps_pkg::SIG_LEN[row]; i++)
            add_byte(rps_pkg::SIG_BYTES[row][i]);
    endtask

    // Build a capture: mostly signatures, some cut short, corrupted or padded
    task automatic build_random_capture();
        int kind;
        int n;
        int cut;
        int r;
        cap_bytes.delete();
        kind = $urandom_range(0, 15);
        if (kind < KIND_SOCKS4)
            load_sig(kind);
        else if (kind == KIND_SOCKS4)
            add_byte(rps_pkg::SOCKS_V4);
        else if (kind == KIND_SOCKS5)
            add_byte(rps_pkg::SOCKS_V5);
        else begin
            n = $urandom_range(1, 16);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
        end
        if (kind < KIND_NOISE) begin
            if ($urandom_range(0, 5) == 0 && cap_bytes.size() > 1) begin
                cut = $urandom_range(1, cap_bytes.size() - 1);
                while (cap_bytes.size() > cut) void'(cap_bytes.pop_back());
            end
            if ($urandom_range(0, 5) == 0)
                cap_bytes[$urandom_range(0, cap_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
            r = $urandom_range(0, 9);
            if (r >= 4) begin
                n = (r == 9) ? $urandom_range(5, 20) : $urandom_range(1, 4);
                repeat (n) add_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Result side: random stalls, one long hold-off to back the block up
    initial begin
        int wait_cycles;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (results_taken % 24 == 0)
                rx_busy = ($urandom_range(0, 2) != 0);
            if (results_taken == 20 && !long_hold_done) begin
                wait_cycles    = 300;
                long_hold_done = 1'b1;
            end else begin
                wait_cycles = rx_busy ? $urandom_range(0, 17) : 0;
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_taken++;
        end
    end

    // Reset, directed captures, random captures, drain and verdict
    initial begin
        int random_start;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // TLS with its third byte, then TLS one byte short
        cap_bytes.delete();
        load_sig(rps_pkg::BIT_TLS);
        add_byte(8'h01);
        send_capture();
        cap_bytes.delete();
        load_sig(rps_pkg::BIT_TLS);
        send_capture();

        // single-byte captures: both SOCKS versions, lowest and highest byte
        cap_bytes = '{rps_pkg::SOCKS_V5};
        send_capture();
        cap_bytes = '{rps_pkg::SOCKS_V4};
        send_capture();
        cap_bytes = '{8'h00};
        send_capture();
        cap_bytes = '{8'hFF};
        send_capture();

        // HTTP, SSH and PROXY
        cap_bytes.delete();
        load_sig(rps_pkg::BIT_HTTP_LO);
        send_capture();
        cap_bytes.delete();
        load_sig(rps_pkg::BIT_SSH);
        send_capture();
        cap_bytes.delete();
        load_sig(rps_pkg::BIT_PROXY1);
        send_capture();

        random_start = sent_items;
        while (sent_items - random_start < RANDOM_BYTES) begin
            build_random_capture();
            send_capture();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
